FILE: hdl/gprb_pkg.sv
`default_nettype none

package gprb_pkg;

    localparam int DEF_NUM_PINS = 54;
    localparam int FSEL_WORDS   = 6;
    localparam int FSEL_BITS    = 30;
    localparam int PINS_PER_FSEL = 10;

    typedef logic [FSEL_BITS-1:0] t_fsel;
    typedef logic [1:0]           t_pull;
    typedef logic [5:0]           t_word_idx;

    localparam logic      CMD_READ  = 1'b0;
    localparam logic      CMD_WRITE = 1'b1;

    localparam t_word_idx W_FSEL0     = 6'd0;
    localparam t_word_idx W_FSEL_LAST = 6'd5;
    localparam t_word_idx W_SET0      = 6'd7;
    localparam t_word_idx W_SET1      = 6'd8;
    localparam t_word_idx W_CLR0      = 6'd10;
    localparam t_word_idx W_CLR1      = 6'd11;
    localparam t_word_idx W_LEV0      = 6'd13;
    localparam t_word_idx W_LEV1      = 6'd14;
    localparam t_word_idx W_PULL      = 6'd37;
    localparam t_word_idx W_PCLK0     = 6'd38;
    localparam t_word_idx W_PCLK1     = 6'd39;

    localparam t_pull      PULL_DOWN_CODE = 2'd1;
    localparam t_pull      PULL_UP_CODE   = 2'd2;
    localparam logic [2:0] FSEL_OUT_CODE  = 3'd1;

    function automatic logic [63:0] f_half_bits(input logic [31:0] data, input logic upper);
        f_half_bits = upper ? {data, 32'h0000_0000} : {32'h0000_0000, data};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/gpio_register_block_top.sv
`default_nettype none

// A word's result is registered and presented in the cycle after the word is accepted.
// Throughput: one word per cycle; a new word is taken whenever the result
// register is empty or its word is being taken in the same cycle.
// Reset: synchronous, active low; clears the state registers, the pull states
// and the result valid flag at once, no clearing pass.

module gpio_register_block_top #(
    parameter int NUM_PINS = gprb_pkg::DEF_NUM_PINS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic                i_cmd,
    input  gprb_pkg::t_word_idx i_word_index,
    input  logic [31:0]         i_write_data,
    input  logic [NUM_PINS-1:0] i_pin_levels,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [31:0]         o_read_data,
    output logic [NUM_PINS-1:0] o_drive_levels,
    output logic [NUM_PINS-1:0] o_drive_enables,
    output logic [NUM_PINS-1:0] o_pull_up_pins,
    output logic [NUM_PINS-1:0] o_pull_down_pins
);
    import gprb_pkg::*;

    t_fsel               r_fsel [FSEL_WORDS];
    t_fsel               n_fsel [FSEL_WORDS];
    t_pull               r_pull [NUM_PINS];
    t_pull               n_pull [NUM_PINS];
    logic [NUM_PINS-1:0] r_latch, n_latch;
    t_pull               r_pull_ctrl, n_pull_ctrl;

    logic                r_valid;
    logic [31:0]         r_read_data, n_read_data;
    logic [NUM_PINS-1:0] r_en, r_up, r_dn;
    logic [NUM_PINS-1:0] w_en, w_up, w_dn;

    logic                w_accept;
    logic                w_write;
    logic [63:0]         w_marks64;
    logic [NUM_PINS-1:0] w_marks;
    logic [63:0]         w_levels64;

    assign o_ready  = !r_valid || i_ready;
    assign w_accept = i_valid && o_ready;
    assign w_write  = (i_cmd == CMD_WRITE);

    assign w_marks64  = f_half_bits(i_write_data, i_word_index == W_SET1 ||
                                    i_word_index == W_CLR1 || i_word_index == W_PCLK1);
    assign w_marks    = w_marks64[NUM_PINS-1:0];
    assign w_levels64 = 64'(i_pin_levels);

    always_comb begin
        n_fsel      = r_fsel;
        n_pull      = r_pull;
        n_latch     = r_latch;
        n_pull_ctrl = r_pull_ctrl;
        n_read_data = 32'h0000_0000;
        case (i_word_index) inside
            [W_FSEL0:W_FSEL_LAST]: begin
                if (w_write) begin
                    n_fsel[i_word_index[2:0]] = i_write_data[FSEL_BITS-1:0];
                end else begin
                    n_read_data = 32'(r_fsel[i_word_index[2:0]]);
                end
            end
            W_SET0, W_SET1: begin
                if (w_write) begin
                    n_latch = r_latch | w_marks;
                end
            end
            W_CLR0, W_CLR1: begin
                if (w_write) begin
                    n_latch = r_latch & ~w_marks;
                end
            end
            W_LEV0: begin
                if (!w_write) begin
                    n_read_data = w_levels64[31:0];
                end
            end
            W_LEV1: begin
                if (!w_write) begin
                    n_read_data = w_levels64[63:32];
                end
            end
            W_PULL: begin
                if (w_write) begin
                    n_pull_ctrl = i_write_data[1:0];
                end else begin
                    n_read_data = 32'(r_pull_ctrl);
                end
            end
            W_PCLK0, W_PCLK1: begin
                if (w_write) begin
                    for (int p = 0; p < NUM_PINS; p++) begin
                        if (w_marks[p]) begin
                            n_pull[p] = r_pull_ctrl;
                        end
                    end
                end
            end
            default: begin
                n_read_data = 32'h0000_0000;
            end
        endcase
    end

    gprb_pin_map #(
        .NUM_PINS(NUM_PINS)
    ) u_pin_map (
        .i_fsel          (n_fsel),
        .i_pull          (n_pull),
        .o_drive_enables (w_en),
        .o_pull_up_pins  (w_up),
        .o_pull_down_pins(w_dn)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < FSEL_WORDS; i++) begin
                r_fsel[i] <= '0;
            end
            for (int p = 0; p < NUM_PINS; p++) begin
                r_pull[p] <= '0;
            end
            r_latch     <= '0;
            r_pull_ctrl <= '0;
            r_valid     <= 1'b0;
        end else begin
            if (w_accept) begin
                r_fsel      <= n_fsel;
                r_pull      <= n_pull;
                r_latch     <= n_latch;
                r_pull_ctrl <= n_pull_ctrl;
                r_valid     <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_read_data <= n_read_data;
            r_en        <= w_en;
            r_up        <= w_up;
            r_dn        <= w_dn;
        end
    end

    assign o_valid          = r_valid;
    assign o_read_data      = r_read_data;
    assign o_drive_levels   = r_latch;
    assign o_drive_enables  = r_en;
    assign o_pull_up_pins   = r_up;
    assign o_pull_down_pins = r_dn;

`ifndef ASSERT_OFF
    a_write_reads_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_write) |=> (r_valid && r_read_data == 32'h0000_0000))
        else $error("write word returned non-zero read data");

    a_pull_disjoint: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> ((r_up & r_dn) == '0))
        else $error("pin pulled both up and down");

    a_latch_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_latch))
        else $error("output latch changed without an accepted word");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> r_valid)
        else $error("stalled with an empty result register");
`endif

endmodule

`default_nettype wire

FILE: hdl/gprb_pin_map.sv
`default_nettype none

module gprb_pin_map #(
    parameter int NUM_PINS = gprb_pkg::DEF_NUM_PINS
) (
    input  var gprb_pkg::t_fsel i_fsel [gprb_pkg::FSEL_WORDS],
    input  var gprb_pkg::t_pull i_pull [NUM_PINS],
    output logic [NUM_PINS-1:0] o_drive_enables,
    output logic [NUM_PINS-1:0] o_pull_up_pins,
    output logic [NUM_PINS-1:0] o_pull_down_pins
);
    import gprb_pkg::*;

    for (genvar p = 0; p < NUM_PINS; p++) begin : g_pin
        localparam int WORD = p / PINS_PER_FSEL;
        localparam int LSB  = (p % PINS_PER_FSEL) * 3;
        if (WORD < FSEL_WORDS) begin : g_fsel
            assign o_drive_enables[p] = (i_fsel[WORD][LSB +: 3] == FSEL_OUT_CODE);
        end else begin : g_no_fsel
            assign o_drive_enables[p] = 1'b0;
        end
        assign o_pull_up_pins[p]   = (i_pull[p] == PULL_UP_CODE);
        assign o_pull_down_pins[p] = (i_pull[p] == PULL_DOWN_CODE);
    end

endmodule

`default_nettype wire
